FILE: rtl/h264_nal_rtp_packetizer_core_assert.svh
// Assertion macros shared by the packetizer RTL.
// Each macro expects ports named clock and reset in the module that uses it.
`ifndef H264_NAL_RTP_PACKETIZER_CORE_ASSERT_SVH
`define H264_NAL_RTP_PACKETIZER_CORE_ASSERT_SVH

// Same-cycle implication.
`define H264NRP_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define H264NRP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/h264nrp_pkg.sv
`default_nettype none

package h264nrp_pkg;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PLAN,
      ST_EMIT
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic capture;
      logic plan;
      logic emit;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic no_result;
      logic final_byte;
      logic slot_free;
   } status_type;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_PAYLOAD  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RTP_PT       = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SOURCE_ID    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TIME_STEP    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHANNEL_ID   = 3'd4;
   localparam int unsigned CSR_DATA_BITS = 32;

   // Register reset values
   localparam logic [11:0] MAX_PAYLOAD_RST  = 12'd1400;
   localparam logic [6:0]  RTP_PT_RST       = 7'd96;
   localparam logic [31:0] SOURCE_ID_RST    = 32'd10000;
   localparam logic [31:0] TIME_STEP_RST    = 32'd22500;
   localparam logic [7:0]  CHANNEL_ID_RST   = 8'd0;

   // Packet format constants
   localparam logic [11:0] MIN_PAYLOAD      = 12'd64;
   localparam logic [4:0]  FU_A_TYPE        = 5'd28;
   localparam logic [7:0]  INTERLEAVE_MAGIC = 8'h24;
   localparam logic [7:0]  RTP_VERSION_BYTE = 8'h80;
   localparam logic [15:0] SINGLE_LEN_ADD   = 16'd12;
   localparam logic [15:0] FU_START_LEN_ADD = 16'd13;
   localparam logic [15:0] FU_LEN_ADD       = 16'd14;

   // Byte positions within one run of output words
   localparam int unsigned POS_BITS = 5;
   localparam logic [POS_BITS-1:0] POS_FIRST    = 5'd0;
   localparam logic [POS_BITS-1:0] POS_HDR_LAST = 5'd15;
   localparam logic [POS_BITS-1:0] POS_FU_IND   = 5'd16;
   localparam logic [POS_BITS-1:0] POS_FU_HDR   = 5'd17;
   localparam logic [POS_BITS-1:0] POS_DATA     = 5'd18;

endpackage

`default_nettype wire

FILE: rtl/h264nrp_ctrl.sv
`default_nettype none

module h264nrp_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire h264nrp_pkg::status_type status,
   output h264nrp_pkg::cmd_type         cmd
);
   import h264nrp_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_PLAN;
         end
         ST_PLAN: begin
            state_in = status.no_result ? ST_IDLE : ST_EMIT;
         end
         ST_EMIT: begin
            if (status.slot_free && status.final_byte) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.plan    = 1'b0;
      cmd.emit    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_PLAN: begin
            cmd.plan = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = status.slot_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/h264nrp_dpath.sv
`default_nettype none

`include "h264_nal_rtp_packetizer_core_assert.svh"

module h264nrp_dpath #(
   parameter int unsigned LENGTH_BITS = 24
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_wr_en,
   input  wire logic [h264nrp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [h264nrp_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  wire logic [7:0]                             req_data_byte,
   input  wire logic                                   req_first_of_nal,
   input  wire logic [LENGTH_BITS-1:0]                 req_nal_length,
   input  wire logic                                   req_mark_single,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic [7:0]                                  rsp_out_byte,
   output logic                                        rsp_packet_end,
   output logic                                        rsp_last_of_run,
   input  wire h264nrp_pkg::cmd_type                   cmd,
   output h264nrp_pkg::status_type                     status
);
   import h264nrp_pkg::*;

   // Configuration
   logic [11:0] max_payload_ff;
   logic [6:0]  rtp_pt_ff;
   logic [31:0] source_id_ff;
   logic [31:0] time_step_ff;
   logic [7:0]  channel_id_ff;

   // Stream state
   logic [15:0]            seq_ff, seq_in;
   logic [31:0]            time_ff, time_in;
   logic [LENGTH_BITS-1:0] remain_ff, remain_in;
   logic [11:0]            fill_ff, fill_in;
   logic [7:0]             nal_hdr_ff, nal_hdr_in;
   logic                   frag_mode_ff, frag_mode_in;

   // Captured input word
   logic [7:0]             in_byte_ff;
   logic                   in_first_ff;
   logic [LENGTH_BITS-1:0] in_len_ff;
   logic                   in_mark_ff;

   // Plan for the current run
   logic [15:0]         pkt_len_ff, pkt_len_in;
   logic                mark_ff, mark_in;
   logic                fu_start_ff, fu_start_in;
   logic                fu_end_ff, fu_end_in;
   logic                has_fu_ff, has_fu_in;
   logic                has_data_ff, has_data_in;
   logic                data_end_ff, data_end_in;
   logic [POS_BITS-1:0] pos_ff, pos_in;

   // Output register
   logic       rsp_valid_ff;
   logic [7:0] rsp_byte_ff;
   logic       rsp_packet_end_ff;
   logic       rsp_last_ff;

   logic [11:0]            eff_max;
   logic [LENGTH_BITS-1:0] max_ext;
   logic                   fits_first;
   logic                   fits_frag;
   logic [11:0]            chunk;
   logic [POS_BITS-1:0]    pos_next;
   logic                   final_byte;
   logic [127:0]           rtp_hdr;
   logic [7:0]             cur_byte;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff  <= MAX_PAYLOAD_RST;
         rtp_pt_ff       <= RTP_PT_RST;
         source_id_ff    <= SOURCE_ID_RST;
         time_step_ff    <= TIME_STEP_RST;
         channel_id_ff   <= CHANNEL_ID_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MAX_PAYLOAD:  max_payload_ff  <= csr_wdata[11:0];
            CSR_RTP_PT:       rtp_pt_ff       <= csr_wdata[6:0];
            CSR_SOURCE_ID:    source_id_ff    <= csr_wdata[31:0];
            CSR_TIME_STEP:    time_step_ff    <= csr_wdata[31:0];
            CSR_CHANNEL_ID:   channel_id_ff   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Capture the accepted word
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         in_byte_ff  <= req_data_byte;
         in_first_ff <= req_first_of_nal;
         in_len_ff   <= req_nal_length;
         in_mark_ff  <= req_mark_single;
      end
   end

   assign eff_max    = (max_payload_ff < MIN_PAYLOAD) ? MIN_PAYLOAD : max_payload_ff;
   assign max_ext    = LENGTH_BITS'(eff_max);
   assign fits_first = (in_len_ff <= max_ext);
   assign fits_frag  = (remain_ff <= max_ext);
   assign chunk      = fits_frag ? remain_ff[11:0] : eff_max;

   assign pos_next   = (pos_ff == POS_HDR_LAST && !has_fu_ff) ? POS_DATA : pos_ff + 5'd1;
   assign final_byte = has_data_ff ? (pos_ff == POS_DATA) : (pos_ff == POS_FU_HDR);

   assign status.no_result  = in_first_ff ? (in_len_ff == '0) : (remain_ff == '0);
   assign status.final_byte = final_byte;
   assign status.slot_free  = !rsp_valid_ff || rsp_ready;

   // Plan the run, then advance through it
   always_comb begin
      seq_in       = seq_ff;
      time_in      = time_ff;
      remain_in    = remain_ff;
      fill_in      = fill_ff;
      nal_hdr_in   = nal_hdr_ff;
      frag_mode_in = frag_mode_ff;
      pkt_len_in   = pkt_len_ff;
      mark_in      = mark_ff;
      fu_start_in  = fu_start_ff;
      fu_end_in    = fu_end_ff;
      has_fu_in    = has_fu_ff;
      has_data_in  = has_data_ff;
      data_end_in  = data_end_ff;
      pos_in       = pos_ff;
      if (cmd.plan) begin
         if (in_first_ff) begin
            remain_in    = '0;
            fill_in      = '0;
            frag_mode_in = 1'b0;
            if (in_len_ff != '0) begin
               nal_hdr_in = in_byte_ff;
               remain_in  = in_len_ff - LENGTH_BITS'(1);
               pos_in     = POS_FIRST;
               if (fits_first) begin
                  pkt_len_in  = in_len_ff[15:0] + SINGLE_LEN_ADD;
                  mark_in     = in_mark_ff;
                  has_fu_in   = 1'b0;
                  fu_start_in = 1'b0;
                  fu_end_in   = 1'b0;
                  has_data_in = 1'b1;
                  fill_in     = in_len_ff[11:0] - 12'd1;
                  data_end_in = (in_len_ff[11:0] == 12'd1);
               end else begin
                  pkt_len_in   = {4'b0000, eff_max} + FU_START_LEN_ADD;
                  mark_in      = 1'b0;
                  has_fu_in    = 1'b1;
                  fu_start_in  = 1'b1;
                  fu_end_in    = 1'b0;
                  has_data_in  = 1'b0;
                  data_end_in  = 1'b0;
                  fill_in      = eff_max - 12'd1;
                  frag_mode_in = 1'b1;
               end
            end
         end else if (remain_ff != '0) begin
            has_data_in = 1'b1;
            remain_in   = remain_ff - LENGTH_BITS'(1);
            if (remain_ff == LENGTH_BITS'(1)) frag_mode_in = 1'b0;
            if (fill_ff == '0) begin
               // open the next fragment
               pos_in      = POS_FIRST;
               pkt_len_in  = {4'b0000, chunk} + FU_LEN_ADD;
               mark_in     = fits_frag;
               has_fu_in   = 1'b1;
               fu_start_in = 1'b0;
               fu_end_in   = fits_frag;
               fill_in     = chunk - 12'd1;
               data_end_in = (chunk == 12'd1);
            end else begin
               pos_in      = POS_DATA;
               fill_in     = fill_ff - 12'd1;
               data_end_in = (fill_ff == 12'd1);
            end
         end
      end else if (cmd.emit) begin
         pos_in = pos_next;
         if (pos_ff == POS_HDR_LAST) begin
            seq_in = seq_ff + 16'd1;
            if (mark_ff) time_in = time_ff + time_step_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= '0;
         time_ff      <= '0;
         remain_ff    <= '0;
         fill_ff      <= '0;
         nal_hdr_ff   <= '0;
         frag_mode_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         time_ff      <= time_in;
         remain_ff    <= remain_in;
         fill_ff      <= fill_in;
         nal_hdr_ff   <= nal_hdr_in;
         frag_mode_ff <= frag_mode_in;
      end
   end

   always_ff @(posedge clock) begin
      pkt_len_ff  <= pkt_len_in;
      mark_ff     <= mark_in;
      fu_start_ff <= fu_start_in;
      fu_end_ff   <= fu_end_in;
      has_fu_ff   <= has_fu_in;
      has_data_ff <= has_data_in;
      data_end_ff <= data_end_in;
      pos_ff      <= pos_in;
   end

   // Interleave prefix and RTP header, first byte in the top bits
   assign rtp_hdr = {INTERLEAVE_MAGIC, channel_id_ff, pkt_len_ff, RTP_VERSION_BYTE,
                     mark_ff, rtp_pt_ff, seq_ff, time_ff, source_id_ff};

   always_comb begin
      case (pos_ff)
         POS_FU_IND: cur_byte = {nal_hdr_ff[7:5], FU_A_TYPE};
         POS_FU_HDR: cur_byte = {fu_start_ff, fu_end_ff, 1'b0, nal_hdr_ff[4:0]};
         POS_DATA:   cur_byte = in_byte_ff;
         default:    cur_byte = rtp_hdr[{~pos_ff[3:0], 3'b000} +: 8];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_byte_ff       <= cur_byte;
         rsp_packet_end_ff <= (pos_ff == POS_DATA) && data_end_ff;
         rsp_last_ff       <= final_byte;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_packet_end  = rsp_packet_end_ff;
   assign rsp_last_of_run = rsp_last_ff;

   `H264NRP_ASSERT_IMP(a_fill_empty_only_in_frag, (fill_ff == '0 && remain_ff != '0), frag_mode_ff, "packet closed with NAL bytes left outside fragment mode")
   `H264NRP_ASSERT_NEXT(a_seq_advance, (cmd.emit && pos_ff == POS_HDR_LAST), (seq_ff == $past(seq_ff) + 16'd1), "sequence number did not advance after header")
   `H264NRP_ASSERT_IMP(a_packet_end_is_last, (rsp_valid_ff && rsp_packet_end_ff), rsp_last_ff, "packet end on a word that is not last of its run")

endmodule

`default_nettype wire

FILE: rtl/h264_nal_rtp_packetizer_core.sv
`default_nettype none

// H.264 NAL to RTSP-interleaved RTP packetizer. NAL bytes enter one word at a
// time on req_*, the header byte flagged by req_first_of_nal and carrying the
// total NAL length; rsp_* returns the packet stream one byte per word, each
// packet being '$', the channel byte, a 16-bit length, a 12-byte RTP header
// and the payload. A NAL of up to max_payload bytes (values below 64 act as
// 64) goes out whole with the marker from req_mark_single; a longer one is cut
// into FU-A fragments, the last one marked. Every packet advances the
// sequence number and a marked packet advances the timestamp by time_step.
// Flow: each input word is captured, planned and then played out through a
// single output register, and the next word is taken only once its run is
// done; a stray or zero-length word is dropped at planning. A held output
// word that meets rsp_ready low stalls the run. Registers on csr_* may be
// written only while no word is in flight.
module h264_nal_rtp_packetizer_core #(
   parameter int unsigned LENGTH_BITS = 24
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // configuration write port
   input  wire logic                                   csr_wr_en,
   input  wire logic [h264nrp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [h264nrp_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   // NAL byte input
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic [7:0]                             req_data_byte,
   input  wire logic                                   req_first_of_nal,
   input  wire logic [LENGTH_BITS-1:0]                 req_nal_length,
   input  wire logic                                   req_mark_single,
   // packet byte output
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic [7:0]                                  rsp_out_byte,
   output logic                                        rsp_packet_end,
   output logic                                        rsp_last_of_run
);
   import h264nrp_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer: capture, plan, then drain one run of words
   h264nrp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Registers, counters, header build and output word
   h264nrp_dpath #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_data_byte    (req_data_byte),
      .req_first_of_nal (req_first_of_nal),
      .req_nal_length   (req_nal_length),
      .req_mark_single  (req_mark_single),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_packet_end   (rsp_packet_end),
      .rsp_last_of_run  (rsp_last_of_run),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

`default_nettype wire
